/* rtl/adsrv_pkg.sv */
package adsrv_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned TimeBitsDef     = 24;
  localparam int unsigned SampleBitsDef   = 16;
  localparam int unsigned CurveEntriesDef = 256;

  // Gains and levels are Q1.16, so unity needs 17 bits.
  localparam int unsigned GainBits   = 17;
  localparam int unsigned CfgIdxBits = 3;
  localparam logic [GainBits-1:0] Unity = 17'h10000;

  typedef enum logic [CfgIdxBits-1:0] {
    CfgAttack  = 3'd0,
    CfgDecay   = 3'd1,
    CfgRelease = 3'd2,
    CfgSustain = 3'd3,
    CfgVolume  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    TrigNone = 2'd0,
    TrigOn   = 2'd1,
    TrigOff  = 2'd2
  } trig_e;

  typedef enum logic [2:0] {
    PhOff     = 3'd0,
    PhAttack  = 3'd1,
    PhDecay   = 3'd2,
    PhSustain = 3'd3,
    PhRelease = 3'd4
  } phase_e;

  // Operand selection and destination of the shared multiplier.
  typedef enum logic [3:0] {
    MulNone  = 4'd0,
    MulVs    = 4'd1,
    MulAtk   = 4'd2,
    MulIdx   = 4'd3,
    MulDecT  = 4'd4,
    MulDecG  = 4'd5,
    MulRel   = 4'd6,
    MulLeft  = 4'd7,
    MulRight = 4'd8
  } mul_op_e;

  typedef enum logic [2:0] {
    GainHold = 3'd0,
    GainZero = 3'd1,
    GainVs   = 3'd2,
    GainVol  = 3'd3,
    GainQuo  = 3'd4
  } gain_src_e;

  typedef struct packed {
    logic      load_in;
    mul_op_e   mul_op;
    logic      div_step;
    logic      rom_rd;
    gain_src_e gain_src;
    logic      tick;
    logic      phase_adv;
    logic      out_load;
  } cmd_t;

  typedef struct packed {
    phase_e phase;
    logic   phase_end;
    logic   div_last;
    logic   out_free;
  } sts_t;

  // Shift-and-subtract quotient, used only while the curve table is built.
  function automatic longint unsigned const_div(input longint unsigned num,
                                                input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = 64'd0;
    rem = 64'd0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Entry of the decay curve: round(2^48 / S), S being the truncated Q32
  // power series of exp(5*idx/entries). Only evaluated at elaboration.
  function automatic logic [15:0] curve_entry(input longint unsigned idx,
                                              input longint unsigned entries);
    longint unsigned term;
    longint unsigned sum;
    longint unsigned den;
    longint unsigned q;
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        den  = entries * 64'(n);
        term = const_div(term * (64'd5 * idx), den);
        sum  = sum + term;
      end
    end
    q = const_div((64'd1 << 48) + (sum >> 1), sum);
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[15:0];
  endfunction

endpackage

/* rtl/adsrv_ctrl.sv */
module adsrv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  adsrv_pkg::sts_t  sts_i,
  output adsrv_pkg::cmd_t  cmd_o
);

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StVs      = 11'b000_0000_0010,
    StEval    = 11'b000_0000_0100,
    StDivLoad = 11'b000_0000_1000,
    StDiv     = 11'b000_0001_0000,
    StQuo     = 11'b000_0010_0000,
    StDecT    = 11'b000_0100_0000,
    StDecG    = 11'b000_1000_0000,
    StRelG    = 11'b001_0000_0000,
    StScaleL  = 11'b010_0000_0000,
    StScaleR  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;
  adsrv_pkg::cmd_t cmd;

  assign in_ready_o = (state_q == StIdle);
  assign cmd_o      = cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd.load_in = 1'b1;
          state_d     = StVs;
        end
      end
      StVs: begin
        cmd.mul_op = adsrv_pkg::MulVs;
        state_d    = StEval;
      end
      StEval: begin
        state_d = StScaleL;
        unique case (sts_i.phase)
          adsrv_pkg::PhAttack: begin
            if (sts_i.phase_end) begin
              cmd.gain_src  = adsrv_pkg::GainVol;
              cmd.phase_adv = 1'b1;
            end else begin
              state_d = StDivLoad;
            end
          end
          adsrv_pkg::PhDecay: begin
            if (sts_i.phase_end) begin
              cmd.gain_src  = adsrv_pkg::GainVs;
              cmd.phase_adv = 1'b1;
            end else begin
              state_d = StDivLoad;
            end
          end
          adsrv_pkg::PhSustain: begin
            cmd.gain_src = adsrv_pkg::GainVs;
          end
          adsrv_pkg::PhRelease: begin
            if (sts_i.phase_end) begin
              cmd.gain_src  = adsrv_pkg::GainZero;
              cmd.phase_adv = 1'b1;
            end else begin
              state_d = StDivLoad;
            end
          end
          default: begin
            cmd.gain_src = adsrv_pkg::GainZero;
          end
        endcase
      end
      StDivLoad: begin
        // Attack divides volume*elapsed; decay and release divide the
        // scaled timer to find the curve index.
        cmd.mul_op = (sts_i.phase == adsrv_pkg::PhAttack) ? adsrv_pkg::MulAtk
                                                          : adsrv_pkg::MulIdx;
        state_d    = StDiv;
      end
      StDiv: begin
        cmd.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = StQuo;
        end
      end
      StQuo: begin
        if (sts_i.phase == adsrv_pkg::PhAttack) begin
          cmd.gain_src = adsrv_pkg::GainQuo;
          cmd.tick     = 1'b1;
          state_d      = StScaleL;
        end else begin
          cmd.rom_rd = 1'b1;
          state_d    = (sts_i.phase == adsrv_pkg::PhDecay) ? StDecT : StRelG;
        end
      end
      StDecT: begin
        cmd.mul_op = adsrv_pkg::MulDecT;
        state_d    = StDecG;
      end
      StDecG: begin
        cmd.mul_op = adsrv_pkg::MulDecG;
        cmd.tick   = 1'b1;
        state_d    = StScaleL;
      end
      StRelG: begin
        cmd.mul_op = adsrv_pkg::MulRel;
        cmd.tick   = 1'b1;
        state_d    = StScaleL;
      end
      StScaleL: begin
        cmd.mul_op = adsrv_pkg::MulLeft;
        state_d    = StScaleR;
      end
      StScaleR: begin
        cmd.mul_op = adsrv_pkg::MulRight;
        if (sts_i.out_free) begin
          cmd.out_load = 1'b1;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* rtl/adsrv_datapath.sv */
module adsrv_datapath #(
  parameter int unsigned TIME_BITS     = adsrv_pkg::TimeBitsDef,
  parameter int unsigned SAMPLE_BITS   = adsrv_pkg::SampleBitsDef,
  parameter int unsigned CURVE_ENTRIES = adsrv_pkg::CurveEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adsrv_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [((TIME_BITS > adsrv_pkg::GainBits) ? TIME_BITS
                 : adsrv_pkg::GainBits)-1:0]  cfg_wdata_i,
  input  logic [1:0]                          trigger_code_i,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample_i,
  input  adsrv_pkg::cmd_t                     cmd_i,
  output adsrv_pkg::sts_t                     sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [SAMPLE_BITS-1:0]       left_scaled_o,
  output logic signed [SAMPLE_BITS-1:0]       right_scaled_o,
  output logic [adsrv_pkg::GainBits-1:0]      envelope_gain_o
);

  localparam int unsigned GB      = adsrv_pkg::GainBits;
  localparam int unsigned WideIn  = (TIME_BITS > SAMPLE_BITS) ? TIME_BITS : SAMPLE_BITS;
  localparam int unsigned MulAW   = ((WideIn > GB) ? WideIn : GB) + 1;
  localparam int unsigned ProdW   = MulAW + GB + 1;
  localparam int unsigned ShrW    = ProdW - 16;
  localparam int unsigned CntW    = $clog2(GB);
  localparam int unsigned IdxW    = $clog2(CURVE_ENTRIES);

  // Configuration registers.
  logic [TIME_BITS-1:0] attack_q, decay_q, release_q;
  logic [GB-1:0]        sustain_q, volume_q;
  logic [GB-1:0]        cfg_level;

  // Envelope state and working registers.
  adsrv_pkg::phase_e    phase_q;
  logic [TIME_BITS-1:0] elapsed_q;
  logic signed [SAMPLE_BITS-1:0] left_in_q, right_in_q, left_q;
  logic [GB-1:0]        vs_q, gain_q, g_q;
  logic [15:0]          e_q;

  // Restoring divider: partial remainder and quotient/dividend shift register.
  logic [TIME_BITS-1:0] rem_q;
  logic [GB-1:0]        quo_q;
  logic [CntW-1:0]      div_cnt_q;
  logic [TIME_BITS:0]   div_trial;
  logic                 div_ge;
  logic [TIME_BITS-1:0] cur_len;

  logic                 out_valid_q;
  logic signed [SAMPLE_BITS-1:0] left_o_q, right_o_q;
  logic [GB-1:0]        gain_o_q;

  logic signed [MulAW-1:0] mul_a;
  logic signed [GB:0]      mul_b;
  logic signed [ProdW-1:0] prod;
  logic [GB-1:0]           prod_gain;
  logic signed [ShrW-1:0]  prod_shr;
  logic signed [ShrW-1:0]  shr_max, shr_min;
  logic signed [SAMPLE_BITS-1:0] prod_sat;

  logic [IdxW-1:0] curve_idx;
  logic [15:0]     curve_rom [CURVE_ENTRIES];
  logic            out_free;

  for (genvar gi = 0; gi < CURVE_ENTRIES; gi++) begin : g_rom
    localparam logic [15:0] CurveVal =
        adsrv_pkg::curve_entry(64'(gi), 64'(CURVE_ENTRIES));
    assign curve_rom[gi] = CurveVal;
  end

  assign cfg_level = (cfg_wdata_i[GB-1:0] > adsrv_pkg::Unity) ? adsrv_pkg::Unity
                                                              : cfg_wdata_i[GB-1:0];

  always_comb begin
    unique case (phase_q)
      adsrv_pkg::PhAttack:  cur_len = attack_q;
      adsrv_pkg::PhDecay:   cur_len = decay_q;
      adsrv_pkg::PhRelease: cur_len = release_q;
      default:              cur_len = '0;
    endcase
  end

  // Shared multiplier; every product lands in a register.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.mul_op)
      adsrv_pkg::MulVs: begin
        mul_a = MulAW'(volume_q);
        mul_b = (GB+1)'(sustain_q);
      end
      adsrv_pkg::MulAtk: begin
        mul_a = MulAW'(elapsed_q);
        mul_b = (GB+1)'(volume_q);
      end
      adsrv_pkg::MulIdx: begin
        mul_a = MulAW'(elapsed_q);
        mul_b = (GB+1)'(CURVE_ENTRIES);
      end
      adsrv_pkg::MulDecT: begin
        mul_a = MulAW'(e_q);
        mul_b = (GB+1)'(adsrv_pkg::Unity - sustain_q);
      end
      adsrv_pkg::MulDecG: begin
        mul_a = MulAW'(g_q);
        mul_b = (GB+1)'(volume_q);
      end
      adsrv_pkg::MulRel: begin
        mul_a = MulAW'(e_q);
        mul_b = (GB+1)'(vs_q);
      end
      adsrv_pkg::MulLeft: begin
        mul_a = MulAW'(left_in_q);
        mul_b = (GB+1)'(gain_q);
      end
      adsrv_pkg::MulRight: begin
        mul_a = MulAW'(right_in_q);
        mul_b = (GB+1)'(gain_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod      = ProdW'(mul_a) * ProdW'(mul_b);
  assign prod_gain = prod[16+GB-1:16];
  // An arithmetic shift gives the floor, also for negative products.
  assign prod_shr  = prod[ProdW-1:16];
  assign shr_max   = ShrW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
  assign shr_min   = ShrW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

  always_comb begin
    if (prod_shr > shr_max) begin
      prod_sat = shr_max[SAMPLE_BITS-1:0];
    end else if (prod_shr < shr_min) begin
      prod_sat = shr_min[SAMPLE_BITS-1:0];
    end else begin
      prod_sat = prod_shr[SAMPLE_BITS-1:0];
    end
  end

  assign div_trial = {rem_q, quo_q[GB-1]};
  assign div_ge    = (div_trial >= {1'b0, cur_len});

  assign curve_idx = (quo_q >= GB'(CURVE_ENTRIES)) ? IdxW'(CURVE_ENTRIES - 1)
                                                   : quo_q[IdxW-1:0];

  assign out_free = !out_valid_q || out_ready_i;

  assign sts_o.phase     = phase_q;
  assign sts_o.phase_end = (elapsed_q >= cur_len);
  assign sts_o.div_last  = (div_cnt_q == CntW'(GB - 1));
  assign sts_o.out_free  = out_free;

  // Configuration and envelope control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q  <= '0;
      decay_q   <= '0;
      release_q <= '0;
      sustain_q <= adsrv_pkg::Unity;
      volume_q  <= adsrv_pkg::Unity;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        adsrv_pkg::CfgAttack:  attack_q  <= cfg_wdata_i[TIME_BITS-1:0];
        adsrv_pkg::CfgDecay:   decay_q   <= cfg_wdata_i[TIME_BITS-1:0];
        adsrv_pkg::CfgRelease: release_q <= cfg_wdata_i[TIME_BITS-1:0];
        adsrv_pkg::CfgSustain: sustain_q <= cfg_level;
        adsrv_pkg::CfgVolume:  volume_q  <= cfg_level;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= adsrv_pkg::PhOff;
      elapsed_q <= '0;
    end else if (cmd_i.load_in) begin
      unique case (trigger_code_i)
        adsrv_pkg::TrigOn: begin
          phase_q   <= adsrv_pkg::PhAttack;
          elapsed_q <= '0;
        end
        adsrv_pkg::TrigOff: begin
          phase_q   <= adsrv_pkg::PhRelease;
          elapsed_q <= '0;
        end
        default: ;
      endcase
    end else if (cmd_i.phase_adv) begin
      unique case (phase_q)
        adsrv_pkg::PhAttack: begin
          phase_q   <= adsrv_pkg::PhDecay;
          elapsed_q <= '0;
        end
        adsrv_pkg::PhDecay:   phase_q <= adsrv_pkg::PhSustain;
        default:              phase_q <= adsrv_pkg::PhOff;
      endcase
    end else if (cmd_i.tick && (elapsed_q != '1)) begin
      elapsed_q <= elapsed_q + TIME_BITS'(1);
    end
  end

  // Working registers of one frame.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      left_in_q  <= left_sample_i;
      right_in_q <= right_sample_i;
    end
    if (cmd_i.mul_op == adsrv_pkg::MulVs) begin
      vs_q <= prod_gain;
    end
    if (cmd_i.mul_op == adsrv_pkg::MulDecT) begin
      g_q <= sustain_q + prod_gain;
    end
    if (cmd_i.mul_op == adsrv_pkg::MulLeft) begin
      left_q <= prod_sat;
    end
    if (cmd_i.rom_rd) begin
      e_q <= curve_rom[curve_idx];
    end
    if ((cmd_i.mul_op == adsrv_pkg::MulDecG) || (cmd_i.mul_op == adsrv_pkg::MulRel)) begin
      gain_q <= (prod_gain > adsrv_pkg::Unity) ? adsrv_pkg::Unity : prod_gain;
    end else begin
      unique case (cmd_i.gain_src)
        adsrv_pkg::GainZero: gain_q <= '0;
        adsrv_pkg::GainVs:   gain_q <= vs_q;
        adsrv_pkg::GainVol:  gain_q <= volume_q;
        adsrv_pkg::GainQuo:  gain_q <= quo_q;
        default: ;
      endcase
    end
    if ((cmd_i.mul_op == adsrv_pkg::MulAtk) || (cmd_i.mul_op == adsrv_pkg::MulIdx)) begin
      // The dividend's top part is already below the divisor, so 17 steps
      // produce the whole quotient.
      rem_q <= prod[TIME_BITS+GB-1:GB];
      quo_q <= prod[GB-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? TIME_BITS'(div_trial - {1'b0, cur_len})
                      : div_trial[TIME_BITS-1:0];
      quo_q <= {quo_q[GB-2:0], div_ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if ((cmd_i.mul_op == adsrv_pkg::MulAtk) || (cmd_i.mul_op == adsrv_pkg::MulIdx)) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CntW'(1);
    end
  end

  // Output register: a finished beat waits here while the next frame is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      left_o_q  <= left_q;
      right_o_q <= prod_sat;
      gain_o_q  <= gain_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_scaled_o   = left_o_q;
  assign right_scaled_o  = right_o_q;
  assign envelope_gain_o = gain_o_q;

endmodule

/* rtl/adsr_envelope_stereo_vca_core.sv */
// An input beat passes through fewer states when no ramp runs (off, sustain,
// or the frame that ends a phase) than in attack, decay and release, where the
// 17-step restoring divider runs. The next frame can be taken in the cycle
// after the previous result is loaded. Reset (rst_ni, asynchronous, active
// low) puts the
// envelope in the off phase, clears the timer and restores the register defaults.
module adsr_envelope_stereo_vca_core #(
  parameter int unsigned TIME_BITS     = adsrv_pkg::TimeBitsDef,
  parameter int unsigned SAMPLE_BITS   = adsrv_pkg::SampleBitsDef,
  parameter int unsigned CURVE_ENTRIES = adsrv_pkg::CurveEntriesDef
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [adsrv_pkg::CfgIdxBits-1:0]    cfg_idx_i,
  input  logic [((TIME_BITS > adsrv_pkg::GainBits) ? TIME_BITS
                 : adsrv_pkg::GainBits)-1:0]  cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          trigger_code_i,
  input  logic signed [SAMPLE_BITS-1:0]       left_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]       right_sample_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       left_scaled_o,
  output logic signed [SAMPLE_BITS-1:0]       right_scaled_o,
  output logic [adsrv_pkg::GainBits-1:0]      envelope_gain_o
);

  adsrv_pkg::cmd_t cmd;
  adsrv_pkg::sts_t sts;

  adsrv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  adsrv_datapath #(
    .TIME_BITS     (TIME_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .CURVE_ENTRIES (CURVE_ENTRIES)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .trigger_code_i  (trigger_code_i),
    .left_sample_i   (left_sample_i),
    .right_sample_i  (right_sample_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_ready_i     (out_ready_i),
    .out_valid_o     (out_valid_o),
    .left_scaled_o   (left_scaled_o),
    .right_scaled_o  (right_scaled_o),
    .envelope_gain_o (envelope_gain_o)
  );

  // A frame is worked on alone: right after a beat is taken, no other is.
  a_one_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while a frame is in progress");

  // The controller only loads the output register when it is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("pending result overwritten");

  // The gain never exceeds unity.
  a_gain_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (envelope_gain_o <= adsrv_pkg::Unity))
    else $error("envelope gain above unity");

  // Zero gain silences both channels.
  a_silence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (envelope_gain_o == '0)) |->
      ((left_scaled_o == '0) && (right_scaled_o == '0)))
    else $error("nonzero sample at zero gain");

endmodule
